@@ rtl/core/xkic_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xkic_pkg
// Shared types, constants and the xorshift128 step for the keystream cipher.
// ----------------------------------------------------------------------------
package xkic_pkg;

    localparam int WORD_W    = 32;
    localparam int NUM_KEYS  = 8;
    localparam int KEY_IDX_W = $clog2(NUM_KEYS);
    localparam int ACTION_W  = 3;

    // xorshift128 shift amounts
    localparam int SH_A = 11;
    localparam int SH_B = 19;
    localparam int SH_C = 8;

    // Defaults for the top-level parameters
    localparam int DEF_WINDOW_FIRST  = 128;
    localparam int DEF_WINDOW_LEN    = 16;
    localparam int DEF_POSITION_BITS = 22;

    // Key register indexes; key A words then key B words
    localparam logic [KEY_IDX_W-1:0] KEY_A_W0 = KEY_IDX_W'(0);
    localparam logic [KEY_IDX_W-1:0] KEY_A_W1 = KEY_IDX_W'(1);
    localparam logic [KEY_IDX_W-1:0] KEY_A_W2 = KEY_IDX_W'(2);
    localparam logic [KEY_IDX_W-1:0] KEY_A_W3 = KEY_IDX_W'(3);
    localparam logic [KEY_IDX_W-1:0] KEY_B_W0 = KEY_IDX_W'(4);
    localparam logic [KEY_IDX_W-1:0] KEY_B_W1 = KEY_IDX_W'(5);
    localparam logic [KEY_IDX_W-1:0] KEY_B_W2 = KEY_IDX_W'(6);
    localparam logic [KEY_IDX_W-1:0] KEY_B_W3 = KEY_IDX_W'(7);

    typedef enum logic [ACTION_W-1:0] {
        ACT_DECRYPT   = 3'd0,
        ACT_REENCRYPT = 3'd1,
        ACT_SUM_A     = 3'd2,
        ACT_SUM_B     = 3'd3,
        ACT_SKIP      = 3'd4
    } t_action;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] w;
    } t_gen;

    typedef struct packed {
        logic step;
        logic reseed;
    } t_gen_ctrl;

    function automatic t_gen gen_step(input t_gen g);
        logic [WORD_W-1:0] t;
        t_gen              n;
        t   = g.x ^ (g.x << SH_A);
        n.x = g.y;
        n.y = g.z;
        n.z = g.w;
        n.w = (g.w ^ (g.w >> SH_B)) ^ t ^ (t >> SH_C);
        return n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/xkic_gen.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xkic_gen
// One xorshift128 generator: state registers, reseed mux and one step.
// ----------------------------------------------------------------------------
module xkic_gen (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire xkic_pkg::t_gen_ctrl   i_ctrl,
    input  wire xkic_pkg::t_gen        i_seed,
    output logic [xkic_pkg::WORD_W-1:0] o_ks
);

    xkic_pkg::t_gen r_state;
    xkic_pkg::t_gen cur;
    xkic_pkg::t_gen n_state;

    always_comb begin
        cur     = i_ctrl.reseed ? i_seed : r_state;
        n_state = xkic_pkg::gen_step(cur);
    end

    assign o_ks = n_state.w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_ctrl.step) begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/xorshift_keystream_image_cipher_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift_keystream_image_cipher_unit
// Positional xorshift128 cipher on 32-bit image words: decrypt, re-encrypt
// and checksum, with a pass-through window of word positions.
// ----------------------------------------------------------------------------
//  Channel  Handshake                   Payload
//  in       i_in_valid / o_in_ready     i_action, i_first_word, i_last_word,
//                                       i_data_word
//  out      o_out_valid / i_out_ready   o_out_word, o_sum_raw, o_sum_plain,
//                                       o_sum_ok, o_is_last
//  cfg      i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One transaction per cycle unless the output stalls; the path runs through the input
//  register, then generator step, XOR and sum into the output register.
//  Checksum words other than the last and skip words give no result.
//  Reset (synchronous) clears keys, generators, position and sums.
//  A stalled output holds the input stage; the input register refills when free.
// ----------------------------------------------------------------------------
module xorshift_keystream_image_cipher_unit #(
    parameter int WINDOW_FIRST  = xkic_pkg::DEF_WINDOW_FIRST,
    parameter int WINDOW_LEN    = xkic_pkg::DEF_WINDOW_LEN,
    parameter int POSITION_BITS = xkic_pkg::DEF_POSITION_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [xkic_pkg::KEY_IDX_W-1:0]    i_cfg_index,
    input  wire [xkic_pkg::WORD_W-1:0]       i_cfg_data,
    // input channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire [xkic_pkg::ACTION_W-1:0]     i_action,
    input  wire                              i_first_word,
    input  wire                              i_last_word,
    input  wire [xkic_pkg::WORD_W-1:0]       i_data_word,
    // output channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [xkic_pkg::WORD_W-1:0]      o_out_word,
    output logic [xkic_pkg::WORD_W-1:0]      o_sum_raw,
    output logic [xkic_pkg::WORD_W-1:0]      o_sum_plain,
    output logic                             o_sum_ok,
    output logic                             o_is_last
);

    localparam int W   = xkic_pkg::WORD_W;
    localparam int CMP_W = 34;

    // key registers
    logic [W-1:0] r_key [xkic_pkg::NUM_KEYS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < xkic_pkg::NUM_KEYS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // input register
    logic                            r_s1_valid;
    logic [xkic_pkg::ACTION_W-1:0]   r_s1_action;
    logic                            r_s1_first;
    logic                            r_s1_last;
    logic [W-1:0]                    r_s1_word;
    logic                            s1_go;

    assign s1_go      = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_action <= i_action;
            r_s1_first  <= i_first_word;
            r_s1_last   <= i_last_word;
            r_s1_word   <= i_data_word;
        end
    end

    // generators
    xkic_pkg::t_gen_ctrl gen_ctrl;
    xkic_pkg::t_gen      seed_a;
    xkic_pkg::t_gen      seed_b;
    logic [W-1:0]        ks_a;
    logic [W-1:0]        ks_b;

    always_comb begin
        gen_ctrl.step   = s1_go;
        gen_ctrl.reseed = r_s1_first;
        seed_a.x = r_key[xkic_pkg::KEY_A_W1];
        seed_a.y = r_key[xkic_pkg::KEY_A_W2];
        seed_a.z = r_key[xkic_pkg::KEY_A_W3];
        seed_a.w = r_key[xkic_pkg::KEY_A_W0];
        seed_b.x = r_key[xkic_pkg::KEY_B_W1];
        seed_b.y = r_key[xkic_pkg::KEY_B_W2];
        seed_b.z = r_key[xkic_pkg::KEY_B_W3];
        seed_b.w = r_key[xkic_pkg::KEY_B_W0];
    end

    xkic_gen u_gen_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (gen_ctrl),
        .i_seed  (seed_a),
        .o_ks    (ks_a)
    );

    xkic_gen u_gen_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (gen_ctrl),
        .i_seed  (seed_b),
        .o_ks    (ks_b)
    );

    // position and running sums
    logic [POSITION_BITS-1:0] r_pos;
    logic [W-1:0]             r_raw;
    logic [W-1:0]             r_plain;

    logic [POSITION_BITS-1:0] pos_cur;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         pos_off;
    logic                     win;
    logic [W-1:0]             raw_base;
    logic [W-1:0]             plain_base;
    logic [W-1:0]             ks_sel;
    logic [W-1:0]             plain_word;
    logic [W-1:0]             n_raw;
    logic [W-1:0]             n_plain;
    logic                     emit;
    logic [W-1:0]             n_out_word;
    logic [W-1:0]             n_sum_raw;
    logic [W-1:0]             n_sum_plain;
    logic                     n_sum_ok;

    always_comb begin
        pos_cur    = r_s1_first ? '0 : r_pos;
        pos_ext    = CMP_W'(pos_cur);
        pos_off    = pos_ext - CMP_W'(WINDOW_FIRST);
        win        = (pos_ext >= CMP_W'(WINDOW_FIRST)) && (pos_off < CMP_W'(WINDOW_LEN));
        raw_base   = r_s1_first ? '0 : r_raw;
        plain_base = r_s1_first ? '0 : r_plain;

        ks_sel     = (xkic_pkg::t_action'(r_s1_action) == xkic_pkg::ACT_SUM_A) ? ks_a : ks_b;
        plain_word = win ? r_s1_word : (r_s1_word ^ ks_sel);

        n_raw       = raw_base;
        n_plain     = plain_base;
        emit        = 1'b0;
        n_out_word  = '0;
        n_sum_raw   = '0;
        n_sum_plain = '0;
        n_sum_ok    = 1'b0;

        unique case (xkic_pkg::t_action'(r_s1_action))
            xkic_pkg::ACT_DECRYPT: begin
                emit       = 1'b1;
                n_out_word = win ? r_s1_word : (r_s1_word ^ ks_b);
            end
            xkic_pkg::ACT_REENCRYPT: begin
                emit       = 1'b1;
                n_out_word = win ? r_s1_word : (r_s1_word ^ ks_a ^ ks_b);
            end
            xkic_pkg::ACT_SUM_A, xkic_pkg::ACT_SUM_B: begin
                n_raw       = raw_base + r_s1_word;
                n_plain     = plain_base + plain_word;
                emit        = r_s1_last;
                n_sum_raw   = n_raw;
                n_sum_plain = n_plain;
                n_sum_ok    = (n_plain == '0);
            end
            default: begin
                // skip: advance only
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_raw   <= '0;
            r_plain <= '0;
        end else if (s1_go) begin
            r_pos   <= pos_cur + POSITION_BITS'(1);
            r_raw   <= n_raw;
            r_plain <= n_plain;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_go) begin
            o_out_valid <= emit;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && emit) begin
            o_out_word  <= n_out_word;
            o_sum_raw   <= n_sum_raw;
            o_sum_plain <= n_sum_plain;
            o_sum_ok    <= n_sum_ok;
            o_is_last   <= r_s1_last;
        end
    end

    // checks
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("pending transaction dropped from output register");

    a_decrypt_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && (r_s1_action == xkic_pkg::ACT_DECRYPT ||
                  r_s1_action == xkic_pkg::ACT_REENCRYPT) |=> o_out_valid)
        else $error("cipher word produced no result");

    a_first_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_first |=> r_pos == POSITION_BITS'(1))
        else $error("position did not restart on first word");

    a_sum_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sum_ok |-> o_sum_plain == '0)
        else $error("sum_ok set with nonzero decrypted sum");

endmodule
`default_nettype wire
